### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted table search core: result codes,
// field widths and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned POSITION_W = 4;
    localparam int unsigned ENTRIES_W  = 5;

    // input word opcodes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // result codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef logic signed [VALUE_W-1:0] t_value;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                load_exec;
        logic                sort_start;
        logic                sort_carry;
        logic                sort_step;
        logic                sort_end;
        logic                mark_sorted;
        logic                srch_init;
        logic                srch_probe;
        logic                srch_cmp;
        logic                set_res;
        logic [STATUS_W-1:0] res_code;
        logic                out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic cnt_zero;
        logic cnt_multi;
        logic sorted;
        logic more_steps;
        logic more_passes;
        logic probe_open;
        logic key_eq;
        logic out_free;
    } t_dp_flags;

endpackage : sts_pkg

`default_nettype wire

### rtl/core/sts_if.sv
// ----------------------------------------------------------------------------
// sts_if
// Valid/ready channels of the sorted table search core: request words in,
// result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_in_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    sts_pkg::t_value       value;
    logic                  first;

    modport source (output valid, output cmd, output value, output first, input ready);
    modport sink   (input valid, input cmd, input value, input first, output ready);
endinterface : sts_in_if

interface sts_out_if;
    logic                                valid;
    logic                                ready;
    logic [sts_pkg::STATUS_W-1:0]        status;
    logic [sts_pkg::POSITION_W-1:0]      position;
    logic [sts_pkg::ENTRIES_W-1:0]       entries;

    modport source (output valid, output status, output position, output entries,
                    input ready);
    modport sink   (input valid, input status, input position, input entries,
                    output ready);
endinterface : sts_out_if

`default_nettype wire

### rtl/core/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer of the sorted table search core: decodes each request word and
// steps the datapath through load, bubble sort passes and binary search probes.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  sts_pkg::t_dp_flags i_flags,
    output sts_pkg::t_dp_cmd   o_cmd
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SORT_CARRY,
        S_SORT_STEP,
        S_SORT_END,
        S_SRCH_ADDR,
        S_SRCH_CMP,
        S_REPLY
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_flags.is_load) begin
                    o_cmd.load_exec = 1'b1;
                    n_state         = S_REPLY;
                end else if (i_flags.cnt_zero) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                    n_state        = S_REPLY;
                end else if (i_flags.sorted) begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRCH_ADDR;
                end else if (i_flags.cnt_multi) begin
                    o_cmd.sort_start = 1'b1;
                    n_state          = S_SORT_CARRY;
                end else begin
                    // a single entry is sorted as it stands
                    o_cmd.mark_sorted = 1'b1;
                    o_cmd.srch_init   = 1'b1;
                    n_state           = S_SRCH_ADDR;
                end
            end
            S_SORT_CARRY: begin
                o_cmd.sort_carry = 1'b1;
                n_state          = S_SORT_STEP;
            end
            S_SORT_STEP: begin
                o_cmd.sort_step = 1'b1;
                n_state         = i_flags.more_steps ? S_SORT_STEP : S_SORT_END;
            end
            S_SORT_END: begin
                o_cmd.sort_end = 1'b1;
                if (i_flags.more_passes) begin
                    n_state = S_SORT_CARRY;
                end else begin
                    o_cmd.mark_sorted = 1'b1;
                    o_cmd.srch_init   = 1'b1;
                    n_state           = S_SRCH_ADDR;
                end
            end
            S_SRCH_ADDR: begin
                if (i_flags.probe_open) begin
                    o_cmd.srch_probe = 1'b1;
                    n_state          = S_SRCH_CMP;
                end else begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_MISSING;
                    n_state        = S_REPLY;
                end
            end
            S_SRCH_CMP: begin
                if (i_flags.key_eq) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FOUND;
                    n_state        = S_REPLY;
                end else begin
                    o_cmd.srch_cmp = 1'b1;
                    n_state        = S_SRCH_ADDR;
                end
            end
            S_REPLY: begin
                if (i_flags.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule : sts_ctrl

`default_nettype wire

### rtl/core/sts_dp.sv
// ----------------------------------------------------------------------------
// sts_dp
// Datapath of the sorted table search core: table memory, entry count,
// bubble sort carry register, search bounds and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  sts_pkg::t_dp_cmd                     i_cmd,
    output sts_pkg::t_dp_flags                   o_flags,
    input  wire                                  i_in_cmd,
    input  sts_pkg::t_value                      i_in_value,
    input  wire                                  i_in_first,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [sts_pkg::STATUS_W-1:0]         o_out_status,
    output logic [sts_pkg::POSITION_W-1:0]       o_out_position,
    output logic [sts_pkg::ENTRIES_W-1:0]        o_out_entries
);
    import sts_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // request word
    logic                  r_cmd;
    t_value                r_key;
    logic                  r_first;

    logic [CW-1:0]         r_count;
    logic                  r_sorted;

    // sort state
    logic [CW-1:0]         r_pass;
    logic [AW-1:0]         r_j;
    t_value                r_carry;

    // search state, upper bound kept one past the last candidate
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi_ex;
    logic [AW-1:0]         r_mid;

    logic [STATUS_W-1:0]   r_status;
    logic [POSITION_W-1:0] r_position;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [POSITION_W-1:0] r_out_position;
    logic [ENTRIES_W-1:0]  r_out_entries;

    t_value                mem [DEPTH];
    t_value                r_rdata;

    logic [CW-1:0]         count_eff;
    logic                  has_room;
    logic                  carry_gt;
    logic [CW-1:0]         mid_full;
    logic [AW-1:0]         mid;
    logic                  we;
    logic [AW-1:0]         wa;
    t_value                wd;
    logic                  re;
    logic [AW-1:0]         ra;

    assign count_eff = r_first ? '0 : r_count;
    assign has_room  = (count_eff < CW'(DEPTH));
    assign carry_gt  = (r_carry > r_rdata);
    assign mid_full  = r_lo + ((r_hi_ex - CW'(1) - r_lo) >> 1);
    assign mid       = AW'(mid_full);

    assign o_flags.is_load     = (r_cmd == CMD_LOAD);
    assign o_flags.cnt_zero    = (r_count == '0);
    assign o_flags.cnt_multi   = (r_count > CW'(1));
    assign o_flags.sorted      = r_sorted;
    assign o_flags.more_steps  = ((CW+1)'(r_j) + (CW+1)'(r_pass) + (CW+1)'(1))
                                 < (CW+1)'(r_count);
    assign o_flags.more_passes = ((CW+1)'(r_pass) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign o_flags.probe_open  = (r_lo < r_hi_ex);
    assign o_flags.key_eq      = (r_rdata == r_key);
    assign o_flags.out_free    = !r_out_valid || i_out_ready;

    // memory port select
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = r_key;
        re = 1'b0;
        ra = '0;
        if (i_cmd.load_exec) begin
            we = has_room;
            wa = AW'(count_eff);
            wd = r_key;
        end
        if (i_cmd.sort_step) begin
            // smaller one settles at j, larger one rides on
            we = 1'b1;
            wa = r_j;
            wd = carry_gt ? r_rdata : r_carry;
            re = o_flags.more_steps;
            ra = AW'((AW+1)'(r_j) + (AW+1)'(2));
        end
        if (i_cmd.sort_end) begin
            we = 1'b1;
            wa = AW'((AW+1)'(r_j) + (AW+1)'(1));
            wd = r_carry;
            re = 1'b1;
            ra = '0;
        end
        if (i_cmd.sort_start) begin
            re = 1'b1;
            ra = '0;
        end
        if (i_cmd.sort_carry) begin
            re = 1'b1;
            ra = AW'(1);
        end
        if (i_cmd.srch_probe) begin
            re = 1'b1;
            ra = mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_in_cmd;
            r_key   <= i_in_value;
            r_first <= i_in_first;
        end
        if (i_cmd.sort_start) begin
            r_pass <= CW'(1);
        end
        if (i_cmd.sort_carry) begin
            r_carry <= r_rdata;
            r_j     <= '0;
        end
        if (i_cmd.sort_step) begin
            r_carry <= carry_gt ? r_carry : r_rdata;
            if (o_flags.more_steps) begin
                r_j <= r_j + AW'(1);
            end
        end
        if (i_cmd.sort_end) begin
            r_pass <= r_pass + CW'(1);
        end
        if (i_cmd.srch_init) begin
            r_lo    <= '0;
            r_hi_ex <= r_count;
        end
        if (i_cmd.srch_probe) begin
            r_mid <= mid;
        end
        if (i_cmd.srch_cmp) begin
            if (r_key < r_rdata) begin
                r_hi_ex <= CW'(r_mid);
            end else begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
        end
        if (i_cmd.load_exec) begin
            r_status   <= has_room ? ST_LOADED : ST_DROPPED;
            r_position <= '0;
        end
        if (i_cmd.set_res) begin
            r_status   <= i_cmd.res_code;
            r_position <= (i_cmd.res_code == ST_FOUND) ? POSITION_W'(r_mid) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status   <= r_status;
            r_out_position <= r_position;
            r_out_entries  <= ENTRIES_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sorted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_exec) begin
                r_sorted <= 1'b0;
                r_count  <= has_room ? count_eff + CW'(1) : count_eff;
            end
            if (i_cmd.mark_sorted) begin
                r_sorted <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_position = r_out_position;
    assign o_out_entries  = r_out_entries;

endmodule : sts_dp

`default_nettype wire

### rtl/core/sorted_table_search_core.sv
// load: the accepted word is decoded and written into the table, then the result is registered
// search of a sorted table: one table memory read and one compare per binary search probe
// first search after a load of more than one entry adds a bubble sort, in which each step
// writes one table entry and, but for the last step of a pass, reads the next one
// throughput: one word at a time, next word accepted once the result is registered
// reset: synchronous active low, clears entry count, sorted flag, state, output valid
// ----------------------------------------------------------------------------
// sorted_table_search_core
// Table of signed values loaded word by word, bubble sorted on demand and
// searched by binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_search_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sts_in_if.sink    i_req,
    sts_out_if.source o_rsp
);
    import sts_pkg::*;

    t_dp_cmd   dp_cmd;
    t_dp_flags dp_flags;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_flags    (dp_flags),
        .o_cmd      (dp_cmd)
    );

    sts_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_flags        (dp_flags),
        .i_in_cmd       (i_req.cmd),
        .i_in_value     (i_req.value),
        .i_in_first     (i_req.first),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_out_status   (o_rsp.status),
        .o_out_position (o_rsp.position),
        .o_out_entries  (o_rsp.entries)
    );

endmodule : sorted_table_search_core

`default_nettype wire

### rtl/core/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port level checks of the sorted table search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               i_in_ready,
    input wire                               i_out_valid,
    input wire                               i_out_ready,
    input wire [sts_pkg::STATUS_W-1:0]       i_status,
    input wire [sts_pkg::POSITION_W-1:0]     i_position,
    input wire [sts_pkg::ENTRIES_W-1:0]      i_entries
);
    import sts_pkg::*;

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_position) && $stable(i_entries))
        else $error("stalled result word changed");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_FOUND) |-> (i_position == '0))
        else $error("position set without a match");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |-> (i_entries == '0))
        else $error("empty status with entries held");

endmodule : sts_checker

bind sorted_table_search_core sts_checker u_sts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_position  (o_rsp.position),
    .i_entries   (o_rsp.entries)
);

`default_nettype wire

### verif/sorted_table_search_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_search_core_tb
// Self-checking bench for the sorted table search core. Drives load and search
// words through the request channel with random gaps. Predicts each result
// word from its own copy of the table, sorted flag and entry count, and checks
// every response field in order. Covers the directed corner cases, back-to-back
// traffic, a long response hold-off and a long random run of table sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          IDLE_PCT     = 26;
    localparam t_value      V_MIN        = 32'sh8000_0000;
    localparam t_value      V_MAX        = 32'sh7fff_ffff;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [POSITION_W-1:0] position;
        logic [ENTRIES_W-1:0]  entries;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    sts_in_if  req_if ();
    sts_out_if rsp_if ();

    sorted_table_search_core #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor state
    t_value  tbl [DEPTH];
    int      held;
    bit      ordered;

    t_result expected_results [$];
    int      errors;
    int      words_sent;
    int      src_idle_pct;
    int      snk_idle_pct;
    bit      hold_req;
    int      hold_left;
    int      quiet_cycles;

    always #5 i_clk = ~i_clk;

    // apply one word to the predictor and return the result it must produce
    function automatic t_result table_result(input logic cmd, input t_value value,
                                             input logic first);
        t_result r;
        t_value  swap;
        int      lo;
        int      hi;
        int      mid;
        r.status   = ST_LOADED;
        r.position = '0;
        if (cmd == CMD_LOAD) begin
            if (first)
                held = 0;
            ordered = 1'b0;
            if (held < DEPTH) begin
                tbl[held] = value;
                held++;
            end else begin
                r.status = ST_DROPPED;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            if (!ordered) begin
                for (int pass = 1; pass < held; pass++) begin
                    for (int j = 0; j + pass < held; j++) begin
                        if (tbl[j] > tbl[j+1]) begin
                            swap     = tbl[j];
                            tbl[j]   = tbl[j+1];
                            tbl[j+1] = swap;
                        end
                    end
                end
                ordered = 1'b1;
            end
            lo = 0;
            hi = held - 1;
            r.status = ST_MISSING;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (tbl[mid] == value) begin
                    r.status   = ST_FOUND;
                    r.position = mid[POSITION_W-1:0];
                    break;
                end
                if (value < tbl[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        r.entries = held[ENTRIES_W-1:0];
        return r;
    endfunction

    task automatic send_word(input logic cmd, input t_value value, input logic first);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.value <= value;
        req_if.first <= first;
        do @(posedge i_clk); while (!req_if.ready);
        expected_results.push_back(table_result(cmd, value, first));
        words_sent++;
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 5))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // table sequences: a load run, mostly from a fresh table, then searches that mostly hit
    task automatic run_sequences(input int n_words);
        t_value keys [DEPTH];
        t_value key;
        int     stop_at;
        int     kind;
        int     n_loads;
        int     n_keys;
        bit     narrow;
        logic   first;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19)
                                                      : $urandom_range(1, 12);
                narrow  = 1'($urandom_range(0, 1));
                n_keys  = 0;
                for (int i = 0; i < n_loads; i++) begin
                    key = narrow ? $signed($urandom_range(0, 12)) - 6 : pick_value();
                    if (i == 0)
                        first = (kind != 1);
                    else
                        first = (kind == 2) ? $urandom_range(0, 7) == 0 : 1'b0;
                    send_word(CMD_LOAD, key, first);
                    if (n_keys < DEPTH) begin
                        keys[n_keys] = key;
                        n_keys++;
                    end
                end
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 5))
                        0:       key = pick_value();
                        1:       key = keys[$urandom_range(0, n_keys - 1)] + 1;
                        default: key = keys[$urandom_range(0, n_keys - 1)];
                    endcase
                    send_word(CMD_SEARCH, key, 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_directed();
        send_word(CMD_SEARCH, 0, 1'b0);
        send_word(CMD_SEARCH, V_MAX, 1'b1);
        send_word(CMD_LOAD, 5, 1'b1);
        send_word(CMD_SEARCH, 5, 1'b0);
        send_word(CMD_LOAD, V_MIN, 1'b0);
        send_word(CMD_LOAD, V_MAX, 1'b0);
        send_word(CMD_LOAD, 5, 1'b0);
        send_word(CMD_LOAD, -1, 1'b0);
        send_word(CMD_SEARCH, V_MIN, 1'b0);
        send_word(CMD_SEARCH, V_MAX, 1'b1);
        send_word(CMD_SEARCH, 5, 1'b0);
        send_word(CMD_SEARCH, 0, 1'b0);
        for (int i = 0; i < 11; i++)
            send_word(CMD_LOAD, i * 7 - 30, 1'b0);
        // table is full now: drop, resort after the drop, then restart
        send_word(CMD_LOAD, 77, 1'b0);
        send_word(CMD_SEARCH, V_MAX, 1'b0);
        send_word(CMD_LOAD, -9, 1'b1);
        send_word(CMD_SEARCH, -9, 1'b0);
    endtask

    task automatic test_back_to_back();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_sequences(150);
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
    endtask

    // response side stalls while words keep coming, so the core backs up
    task automatic test_response_hold();
        hold_req = 1'b1;
        run_sequences(40);
    endtask

    task automatic test_random_tables();
        run_sequences(1080);
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with none expected: status %0d", rsp_if.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.position !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, rsp_if.position);
                    errors++;
                end
                if (rsp_if.entries !== want.entries) begin
                    $error("entries: expected %0d, actual %0d",
                           want.entries, rsp_if.entries);
                    errors++;
                end
            end
        end
        if (hold_left == 0 && hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_LOAD;
        req_if.value = '0;
        req_if.first = 1'b0;
        rsp_if.ready = 1'b0;
        held         = 0;
        ordered      = 1'b0;
        errors       = 0;
        words_sent   = 0;
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        hold_req     = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        foreach (tbl[i])
            tbl[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_response_hold();
        test_random_tables();

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule : sorted_table_search_core_tb

`default_nettype wire

### files.f
rtl/core/sts_pkg.sv
rtl/core/sts_if.sv
rtl/core/sts_ctrl.sv
rtl/core/sts_dp.sv
rtl/core/sorted_table_search_core.sv
rtl/core/sts_checker.sv
verif/sorted_table_search_core_tb.sv
